@@ design/crs_pkg.sv @@
// Shared types, codes and constants of the clip rectangle stack.
package crs_pkg;

   localparam int WIDE_W     = 21;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_POP   = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd2;
   localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd3;
   localparam logic [2:0] REG_OFFSET_X      = 3'd4;
   localparam logic [2:0] REG_OFFSET_Y      = 3'd5;
   localparam logic [2:0] REG_ROTATION      = 3'd6;

   localparam logic signed [WIDE_W-1:0] WIDE_ZERO = '0;
   localparam logic signed [WIDE_W-1:0] POS_MIN   = WIDE_W'(-32768);
   localparam logic signed [WIDE_W-1:0] POS_MAX   = WIDE_W'(32767);
   localparam logic signed [WIDE_W-1:0] SIZE_MAX  = WIDE_W'(32767);

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] size_w;
      logic signed [15:0] size_h;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] scissor_x;
      logic signed [15:0] scissor_y;
      logic [14:0]        scissor_w;
      logic [14:0]        scissor_h;
      logic               clipping_on;
      logic               visible;
      logic [1:0]         status;
   } rsp_word_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] w;
      logic signed [15:0] h;
   } rect_type;

   typedef struct packed {
      rect_type win;
      rect_type lgc;
   } entry_type;

   typedef struct packed {
      logic signed [WIDE_W-1:0] x;
      logic signed [WIDE_W-1:0] y;
      logic signed [WIDE_W-1:0] w;
      logic signed [WIDE_W-1:0] h;
   } wide_rect_type;

   typedef struct packed {
      logic [12:0]        screen_width;
      logic [12:0]        screen_height;
      logic [12:0]        window_width;
      logic [12:0]        window_height;
      logic signed [13:0] offset_x;
      logic signed [13:0] offset_y;
      logic [1:0]         rotation;
   } cfg_type;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

endpackage

@@ design/crs_cell.sv @@
// One stack cell: holds an entry and shifts it towards or away from the top.
module crs_cell import crs_pkg::*; (
   input  logic      clock,
   input  shift_type shift,
   input  entry_type up_word,
   input  entry_type down_word,
   output entry_type entry
);

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift.push) begin
         entry_ff <= up_word;
      end else if (shift.pop) begin
         entry_ff <= down_word;
      end
   end

   assign entry = entry_ff;

endmodule

@@ design/crs_map.sv @@
// Edge extension, rotation mapping to window space and the visibility query.
module crs_map import crs_pkg::*; (
   input  cfg_type       cfg,
   input  req_word_type  word,
   input  rect_type      top_lgc,
   input  logic          stack_empty,
   output wide_rect_type mapped,
   output logic          visible
);

   logic signed [WIDE_W-1:0] px, py, pw, ph;
   logic signed [WIDE_W-1:0] sw, sh, ww, wh, ox, oy;
   logic signed [WIDE_W-1:0] bw, bh;
   logic signed [WIDE_W-1:0] tx, ty, tw, th;
   logic signed [WIDE_W-1:0] q_right, q_bottom;
   logic                     reject, scr_x, scr_y, top_x, top_y;

   assign px = WIDE_W'(word.pos_x);
   assign py = WIDE_W'(word.pos_y);
   assign pw = WIDE_W'(word.size_w);
   assign ph = WIDE_W'(word.size_h);
   assign sw = WIDE_W'(cfg.screen_width);
   assign sh = WIDE_W'(cfg.screen_height);
   assign ww = WIDE_W'(cfg.window_width);
   assign wh = WIDE_W'(cfg.window_height);
   assign ox = WIDE_W'(cfg.offset_x);
   assign oy = WIDE_W'(cfg.offset_y);

   assign bw = (pw == '0) ? sw - px : pw;
   assign bh = (ph == '0) ? sh - py : ph;

   always_comb begin
      unique case (cfg.rotation)
         2'd0: begin
            mapped.x = ox + px;
            mapped.y = oy + py;
            mapped.w = bw;
            mapped.h = bh;
         end
         2'd1: begin
            mapped.x = ww - oy - py - bh;
            mapped.y = ox + px;
            mapped.w = bh;
            mapped.h = bw;
         end
         2'd2: begin
            mapped.x = ww - ox - px - bw;
            mapped.y = wh - oy - py - bh;
            mapped.w = bw;
            mapped.h = bh;
         end
         default: begin
            mapped.x = oy + py;
            mapped.y = wh - ox - px - bw;
            mapped.w = bh;
            mapped.h = bw;
         end
      endcase
   end

   assign tx = WIDE_W'(top_lgc.x);
   assign ty = WIDE_W'(top_lgc.y);
   assign tw = WIDE_W'(top_lgc.w);
   assign th = WIDE_W'(top_lgc.h);

   assign q_right  = px + pw;
   assign q_bottom = py + ph;

   assign reject = (pw > WIDE_ZERO && q_right <= WIDE_ZERO)
                   || (ph > WIDE_ZERO && q_bottom <= WIDE_ZERO)
                   || px == sw || py == sh;

   assign scr_x = (px >= WIDE_ZERO && px <= sw) || (px <= WIDE_ZERO && q_right >= WIDE_ZERO);
   assign scr_y = (py >= WIDE_ZERO && py <= sh) || (py <= WIDE_ZERO && q_bottom >= WIDE_ZERO);
   assign top_x = (tx >= px && tx <= q_right) || (px >= tx && px <= tx + tw);
   assign top_y = (ty >= py && ty <= q_bottom) || (py >= ty && py <= ty + th);

   assign visible = !reject && scr_x && scr_y && (stack_empty || (top_x && top_y));

endmodule

@@ design/clip_rect_stack_unit.sv @@
// Top level of the clip rectangle stack: control, register port and the cell chain.
// Each request word is registered, then the map state maps the rectangle and the apply
// state intersects it with the top cell, shifts the cell chain and registers the result
// word once the output is free; a new request word can be taken in that apply step.
// Reset is synchronous and clears the stack count, the control state and the registers;
// the cells are not cleared, as entries above the stack count are never read.
module clip_rect_stack_unit import crs_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_MAP, ST_APPLY} state_type;

   state_type     state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;
   cfg_type       cfg_ff;
   req_word_type  in_ff;
   wide_rect_type map_ff, mapped;
   logic          vis_ff, visible;

   entry_type     cell_q [STACK_DEPTH];
   entry_type     new_entry;
   shift_type     shift;

   logic          take, out_free, apply_go, empty, full;
   logic [2:0]    csr_index;
   logic          csr_write;

   logic signed [WIDE_W-1:0] tx, ty, tw, th;
   logic signed [WIDE_W-1:0] nx, ny, nw, nh, t_right, t_bottom;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(STACK_DEPTH));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign apply_go = (state_ff == ST_APPLY) && out_free;
   assign req_stall = !((state_ff == ST_IDLE) || apply_go);
   assign take     = req_valid && !req_stall;

   // Register port.
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_pwdata[12:0];
            REG_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_pwdata[12:0];
            REG_WINDOW_WIDTH:  cfg_ff.window_width  <= csr_pwdata[12:0];
            REG_WINDOW_HEIGHT: cfg_ff.window_height <= csr_pwdata[12:0];
            REG_OFFSET_X:      cfg_ff.offset_x      <= csr_pwdata[13:0];
            REG_OFFSET_Y:      cfg_ff.offset_y      <= csr_pwdata[13:0];
            REG_ROTATION:      cfg_ff.rotation      <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SCREEN_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.screen_width);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.screen_height);
         REG_WINDOW_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.window_width);
         REG_WINDOW_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.window_height);
         REG_OFFSET_X:      csr_prdata = CSR_DATA_W'(cfg_ff.offset_x);
         REG_OFFSET_Y:      csr_prdata = CSR_DATA_W'(cfg_ff.offset_y);
         REG_ROTATION:      csr_prdata = CSR_DATA_W'(cfg_ff.rotation);
         default:           csr_prdata = '0;
      endcase
   end

   // Mapping stage.
   crs_map u_map (
      .cfg         (cfg_ff),
      .word        (in_ff),
      .top_lgc     (cell_q[0].lgc),
      .stack_empty (empty),
      .mapped      (mapped),
      .visible     (visible)
   );

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff <= req_word;
      end
      if (state_ff == ST_MAP) begin
         map_ff <= mapped;
         vis_ff <= visible;
      end
   end

   // Intersection with the top of the stack and saturation.
   assign tx = WIDE_W'(cell_q[0].win.x);
   assign ty = WIDE_W'(cell_q[0].win.y);
   assign tw = WIDE_W'(cell_q[0].win.w);
   assign th = WIDE_W'(cell_q[0].win.h);
   assign t_right  = tx + tw;
   assign t_bottom = ty + th;

   always_comb begin
      nx = map_ff.x;
      ny = map_ff.y;
      nw = map_ff.w;
      nh = map_ff.h;
      if (!empty) begin
         if (tx > nx) begin
            nx = tx;
         end
         if (ty > ny) begin
            ny = ty;
         end
         if (t_right < nx + map_ff.w) begin
            nw = t_right - nx;
         end
         if (t_bottom < ny + map_ff.h) begin
            nh = t_bottom - ny;
         end
      end
   end

   function automatic logic signed [15:0] sat_pos(input logic signed [WIDE_W-1:0] v);
      if (v < POS_MIN) begin
         return 16'sh8000;
      end else if (v > POS_MAX) begin
         return 16'sh7FFF;
      end
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] sat_size(input logic signed [WIDE_W-1:0] v);
      if (v < WIDE_ZERO) begin
         return '0;
      end else if (v > SIZE_MAX) begin
         return 16'sh7FFF;
      end
      return v[15:0];
   endfunction

   assign new_entry.win.x = sat_pos(nx);
   assign new_entry.win.y = sat_pos(ny);
   assign new_entry.win.w = sat_size(nw);
   assign new_entry.win.h = sat_size(nh);
   assign new_entry.lgc.x = in_ff.pos_x;
   assign new_entry.lgc.y = in_ff.pos_y;
   assign new_entry.lgc.w = in_ff.size_w;
   assign new_entry.lgc.h = in_ff.size_h;

   assign shift.push = apply_go && (in_ff.mode == MODE_PUSH) && !full;
   assign shift.pop  = apply_go && (in_ff.mode == MODE_POP) && !empty;

   // The cell chain; cell zero is the top of the stack.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      entry_type up_word, down_word;
      if (i == 0) begin : g_first
         assign up_word = new_entry;
      end else begin : g_inner
         assign up_word = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign down_word = cell_q[i];
      end else begin : g_body
         assign down_word = cell_q[i+1];
      end
      crs_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .up_word   (up_word),
         .down_word (down_word),
         .entry     (cell_q[i])
      );
   end

   // Result word and control.
   always_comb begin
      rsp_word_in = '0;
      count_in    = count_ff;
      if (shift.push) begin
         count_in = count_ff + CNT_W'(1);
         rsp_word_in.scissor_x   = new_entry.win.x;
         rsp_word_in.scissor_y   = new_entry.win.y;
         rsp_word_in.scissor_w   = new_entry.win.w[14:0];
         rsp_word_in.scissor_h   = new_entry.win.h[14:0];
         rsp_word_in.clipping_on = 1'b1;
      end else if (shift.pop) begin
         count_in = count_ff - CNT_W'(1);
         if (count_ff > CNT_W'(1)) begin
            rsp_word_in.scissor_x   = cell_q[1].win.x;
            rsp_word_in.scissor_y   = cell_q[1].win.y;
            rsp_word_in.scissor_w   = cell_q[1].win.w[14:0];
            rsp_word_in.scissor_h   = cell_q[1].win.h[14:0];
            rsp_word_in.clipping_on = 1'b1;
         end
      end else if (!empty) begin
         rsp_word_in.scissor_x   = cell_q[0].win.x;
         rsp_word_in.scissor_y   = cell_q[0].win.y;
         rsp_word_in.scissor_w   = cell_q[0].win.w[14:0];
         rsp_word_in.scissor_h   = cell_q[0].win.h[14:0];
         rsp_word_in.clipping_on = 1'b1;
      end
      rsp_word_in.visible = (in_ff.mode == MODE_QUERY) && vis_ff;
      if (in_ff.mode == MODE_PUSH && full) begin
         rsp_word_in.status = STATUS_PUSH_FULL;
      end else if (in_ff.mode == MODE_POP && empty) begin
         rsp_word_in.status = STATUS_POP_EMPTY;
      end else begin
         rsp_word_in.status = STATUS_OK;
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE:  state_in = take ? ST_MAP : ST_IDLE;
         ST_MAP:   state_in = ST_APPLY;
         ST_APPLY: state_in = apply_go ? (take ? ST_MAP : ST_IDLE) : ST_APPLY;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = apply_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_word_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply_go) begin
            count_ff    <= count_in;
            rsp_word_ff <= rsp_word_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ design/crs_checker.sv @@
// Port-level checks of the clip rectangle stack, bound to the top level.
module crs_checker import crs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result word withdrawn while stalled.");

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.clipping_on |->
         rsp_word.scissor_x == '0 && rsp_word.scissor_y == '0 &&
         rsp_word.scissor_w == '0 && rsp_word.scissor_h == '0)
      else $error("Scissor rectangle not zero while clipping is off.");

   a_visible_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.visible |-> rsp_word.status == STATUS_OK)
      else $error("Visible answer given with an error status.");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Request word accepted on two consecutive cycles.");

endmodule

bind clip_rect_stack_unit crs_checker u_crs_checker (.*);
